// ===== hw/rtl/nrmb_pkg.sv =====
// Shared types, constants and helper functions of the nucleotide rate matrix builder.
package nrmb_pkg;

  localparam int MODEL_W    = 3;
  localparam int KAPPA_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int FREQ_W   = 17;
  localparam int SEX_W    = 24;
  localparam int PROD_W   = 41;
  localparam int NUM_W    = 43;
  localparam int ROW_LO_W = 22;
  localparam int ROW_HI_W = NUM_W - ROW_LO_W;
  localparam int PLO_W    = ROW_LO_W + FREQ_W;
  localparam int PHI_W    = ROW_HI_W + FREQ_W;
  localparam int SLO_W    = PLO_W + 2;
  localparam int SHI_W    = PHI_W + 2;
  localparam int DEN_W    = 62;
  localparam int DEN3_W   = DEN_W + 2;
  localparam int QUO_W    = 34;
  localparam int VAL_W    = 32;

  localparam int NBASE   = 4;
  localparam int LANES   = NBASE * NBASE;
  localparam int ENT_W   = 4;

  localparam int DIV_STEPS = QUO_W / 2;
  localparam int STEP_W    = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_MODEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KAPPA = 1'b1;

  localparam logic [KAPPA_W-1:0] KAPPA_RESET = 16'd1024;

  localparam logic [SEX_W-1:0]  ONE_Q16     = 24'd65536;
  localparam logic [FREQ_W-1:0] QUARTER_Q16 = 17'd16384;
  localparam logic [SEX_W-1:0]  GTR_AC      = 24'd81112;
  localparam logic [SEX_W-1:0]  GTR_AG      = 24'd235211;
  localparam logic [SEX_W-1:0]  GTR_AT      = 24'd142090;
  localparam logic [SEX_W-1:0]  GTR_CG      = 24'd47908;
  localparam logic [SEX_W-1:0]  GTR_CT      = 24'd452880;

  localparam logic [3:0] PAIR_AC = 4'b0001;
  localparam logic [3:0] PAIR_AG = 4'b0010;
  localparam logic [3:0] PAIR_AT = 4'b0011;
  localparam logic [3:0] PAIR_CG = 4'b0110;
  localparam logic [3:0] PAIR_CT = 4'b0111;

  localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [MODEL_W-1:0] {
    MODEL_JC69  = 3'd0,
    MODEL_F81   = 3'd1,
    MODEL_K2P   = 3'd2,
    MODEL_HKY85 = 3'd3,
    MODEL_GTR   = 3'd4
  } model_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    logic                            valid;
    logic                            zero;
    logic [LANES-1:0][NUM_W-1:0]     num;
    logic [DEN_W-1:0]                den;
    logic [DEN3_W-1:0]               den3;
  } front_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

  typedef struct packed {
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } lane_res_t;

  function automatic model_e eff_model(logic [MODEL_W-1:0] sel);
    model_e m;
    case (sel)
      MODEL_JC69:  m = MODEL_JC69;
      MODEL_F81:   m = MODEL_F81;
      MODEL_K2P:   m = MODEL_K2P;
      MODEL_HKY85: m = MODEL_HKY85;
      MODEL_GTR:   m = MODEL_GTR;
      default:     m = MODEL_F81;
    endcase
    return m;
  endfunction

  function automatic logic [SEX_W-1:0] exch(model_e m, logic [KAPPA_W-1:0] kap,
                                            logic [1:0] a, logic [1:0] b);
    logic [3:0]       pair;
    logic [SEX_W-1:0] res;
    pair = (a < b) ? {a, b} : {b, a};
    res  = ONE_Q16;
    case (m)
      MODEL_K2P, MODEL_HKY85: begin
        if (pair == PAIR_AG || pair == PAIR_CT) begin
          res = {kap, 8'b0};
        end
      end
      MODEL_GTR: begin
        case (pair)
          PAIR_AC: res = GTR_AC;
          PAIR_AG: res = GTR_AG;
          PAIR_AT: res = GTR_AT;
          PAIR_CG: res = GTR_CG;
          PAIR_CT: res = GTR_CT;
          default: res = ONE_Q16;
        endcase
      end
      default: res = ONE_Q16;
    endcase
    return res;
  endfunction

endpackage

// ===== hw/rtl/nrmb_front.sv =====
// Front pipeline: frequencies, weighted rates, row sums and the normalizing total.
module nrmb_front import nrmb_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              in_valid_i,
  input  logic [MODEL_W-1:0]                model_i,
  input  logic [KAPPA_W-1:0]                kappa_i,
  input  logic [NBASE-1:0][FREQ_W-1:0]      freq_i,
  output front_t                            front_o
);

  model_e                                   m1;
  logic [NBASE-1:0][FREQ_W-1:0]             f1_d, f1_q, f2_q;
  logic [NBASE-1:0][NBASE-1:0][PROD_W-1:0]  p1_d, p1_q, p2_q;
  logic [NBASE-1:0][NUM_W-1:0]              row2_d, row2_q;
  logic [NBASE-1:0][PLO_W-1:0]              pl3_d, pl3_q;
  logic [NBASE-1:0][PHI_W-1:0]              ph3_d, ph3_q;
  logic [LANES-1:0][NUM_W-1:0]              num3_d, num3_q, num4_q, num5_q, num6_q;
  logic [SLO_W-1:0]                         slo4_d, slo4_q;
  logic [SHI_W-1:0]                         shi4_d, shi4_q;
  logic [DEN_W-1:0]                         den5_d, den5_q, den6_q;
  logic [DEN3_W-1:0]                        den3_6_d, den3_6_q;
  logic                                     zero6_q;
  logic [5:0]                               v_q;

  always_comb begin
    m1 = eff_model(model_i);
    for (int i = 0; i < NBASE; i++) begin
      f1_d[i] = (m1 == MODEL_JC69 || m1 == MODEL_K2P) ? QUARTER_Q16 : freq_i[i];
    end
    for (int i = 0; i < NBASE; i++) begin
      for (int j = 0; j < NBASE; j++) begin
        if (i == j) begin
          p1_d[i][j] = '0;
        end else begin
          p1_d[i][j] = exch(m1, kappa_i, 2'(i), 2'(j)) * f1_d[j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NBASE; i++) begin
      row2_d[i] = NUM_W'(p1_q[i][0]) + NUM_W'(p1_q[i][1])
                + NUM_W'(p1_q[i][2]) + NUM_W'(p1_q[i][3]);
    end
  end

  always_comb begin
    for (int i = 0; i < NBASE; i++) begin
      pl3_d[i] = row2_q[i][ROW_LO_W-1:0] * f2_q[i];
      ph3_d[i] = row2_q[i][NUM_W-1:ROW_LO_W] * f2_q[i];
      for (int j = 0; j < NBASE; j++) begin
        if (i == j) begin
          num3_d[i*NBASE+j] = row2_q[i];
        end else begin
          num3_d[i*NBASE+j] = NUM_W'(p2_q[i][j]);
        end
      end
    end
  end

  always_comb begin
    slo4_d = '0;
    shi4_d = '0;
    for (int i = 0; i < NBASE; i++) begin
      slo4_d = slo4_d + SLO_W'(pl3_q[i]);
      shi4_d = shi4_d + SHI_W'(ph3_q[i]);
    end
  end

  assign den5_d   = DEN_W'(slo4_q) + {shi4_q, {ROW_LO_W{1'b0}}};
  assign den3_6_d = {2'b00, den5_q} + {1'b0, den5_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[4:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      f1_q     <= f1_d;
      p1_q     <= p1_d;
      f2_q     <= f1_q;
      p2_q     <= p1_q;
      row2_q   <= row2_d;
      pl3_q    <= pl3_d;
      ph3_q    <= ph3_d;
      num3_q   <= num3_d;
      slo4_q   <= slo4_d;
      shi4_q   <= shi4_d;
      num4_q   <= num3_q;
      den5_q   <= den5_d;
      num5_q   <= num4_q;
      den6_q   <= den5_q;
      den3_6_q <= den3_6_d;
      zero6_q  <= (den5_q == '0);
      num6_q   <= num5_q;
    end
  end

  assign front_o.valid = v_q[5];
  assign front_o.zero  = zero6_q;
  assign front_o.num   = num6_q;
  assign front_o.den   = den6_q;
  assign front_o.den3  = den3_6_q;

endmodule

// ===== hw/rtl/nrmb_div_lane.sv =====
// One divider lane: radix-4 restoring fraction divide of an entry by the total.
module nrmb_div_lane import nrmb_pkg::*; (
  input  logic              clk_i,
  input  div_ctrl_t         ctrl_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [DEN3_W-1:0] den3_i,
  output lane_res_t         res_o
);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [QUO_W-1:0]  quo_q;
  logic              ovf_q;
  logic [1:0]        digit;
  logic [DEN3_W-1:0] sh;
  logic [DEN3_W:0]   d1, d2, d3;

  always_comb begin
    sh = {rem_q, 2'b00};
    d1 = {1'b0, sh} - {3'b000, den_i};
    d2 = {1'b0, sh} - {2'b00, den_i, 1'b0};
    d3 = {1'b0, sh} - {1'b0, den3_i};
    if (!d3[DEN3_W]) begin
      digit = 2'd3;
      rem_d = d3[DEN_W-1:0];
    end else if (!d2[DEN3_W]) begin
      digit = 2'd2;
      rem_d = d2[DEN_W-1:0];
    end else if (!d1[DEN3_W]) begin
      digit = 2'd1;
      rem_d = d1[DEN_W-1:0];
    end else begin
      digit = 2'd0;
      rem_d = sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ovf_q <= (DEN_W'(num_i) >= den_i);
      rem_q <= DEN_W'(num_i);
      quo_q <= '0;
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QUO_W-3:0], digit};
    end
  end

  assign res_o.ovf = ovf_q;
  assign res_o.quo = quo_q;

endmodule

// ===== hw/rtl/nrmb_merge.sv =====
// Merge stage: hold the lane results, round and saturate, stream entries row-major.
module nrmb_merge import nrmb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   xfer_i,
  input  lane_res_t [LANES-1:0]  res_i,
  input  logic                   err_i,
  output logic                   buf_free_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             row_index_o,
  output logic [1:0]             col_index_o,
  output logic [VAL_W-1:0]       rate_value_o,
  output logic                   last_entry_o,
  output logic                   norm_error_o
);

  lane_res_t [LANES-1:0] buf_q;
  logic                  berr_q;
  logic                  bvalid_q;
  logic [ENT_W-1:0]      bcnt_q;
  logic                  out_valid_q;
  logic                  out_ld;
  logic                  take_last;
  lane_res_t             sel;
  logic [QUO_W-1:0]      rsum;
  logic [QUO_W-2:0]      mag;
  logic                  diag;
  logic [VAL_W-1:0]      val_d;
  logic [1:0]            row_q, col_q;
  logic [VAL_W-1:0]      val_q;
  logic                  last_q, err_q;

  assign out_ld     = bvalid_q && (!out_valid_q || !out_stall_i);
  assign take_last  = out_ld && (bcnt_q == {ENT_W{1'b1}});
  assign buf_free_o = !bvalid_q || take_last;

  always_comb begin
    sel  = buf_q[bcnt_q];
    diag = (bcnt_q[3:2] == bcnt_q[1:0]);
    rsum = {1'b0, sel.quo[QUO_W-1:1]} + QUO_W'(1);
    mag  = rsum[QUO_W-1:1];
    if (berr_q) begin
      val_d = '0;
    end else if (diag) begin
      if (sel.ovf || mag > (QUO_W-1)'(SAT_NEG)) begin
        val_d = SAT_NEG;
      end else begin
        val_d = '0 - mag[VAL_W-1:0];
      end
    end else begin
      if (sel.ovf || mag > (QUO_W-1)'(SAT_POS)) begin
        val_d = SAT_POS;
      end else begin
        val_d = mag[VAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q    <= 1'b0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (xfer_i) begin
        bvalid_q <= 1'b1;
        bcnt_q   <= '0;
      end else if (out_ld) begin
        bcnt_q <= bcnt_q + ENT_W'(1);
        if (take_last) begin
          bvalid_q <= 1'b0;
        end
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (xfer_i) begin
      buf_q  <= res_i;
      berr_q <= err_i;
    end
    if (out_ld) begin
      row_q  <= bcnt_q[3:2];
      col_q  <= bcnt_q[1:0];
      val_q  <= val_d;
      last_q <= (bcnt_q == {ENT_W{1'b1}});
      err_q  <= berr_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_index_o  = row_q;
  assign col_index_o  = col_q;
  assign rate_value_o = val_q;
  assign last_entry_o = last_q;
  assign norm_error_o = err_q;

endmodule

// ===== hw/rtl/nucleotide_rate_matrix_builder.sv =====
// Top level of the nucleotide substitution rate matrix builder.
// Each item (four base frequencies, unsigned Q1.16) yields the sixteen entries of the
// normalized 4x4 rate matrix of the selected model, row-major, as signed Q15.16 with
// saturation; norm_error flags a zero normalizer and forces the entries to zero.
// An item passes a six-stage front pipeline, then sixteen divider lanes that run in
// parallel, two quotient bits per cycle: a load, then 17 steps. The lanes take a new
// item only once that divide is done and the result buffer is free; the sixteen
// entries leave the buffer one per cycle while out_stall is low, as the lanes work on
// the next item. The model_select and kappa_ratio registers are read as an item enters.
module nucleotide_rate_matrix_builder import nrmb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [FREQ_W-1:0]      freq_a_i,
  input  logic [FREQ_W-1:0]      freq_c_i,
  input  logic [FREQ_W-1:0]      freq_g_i,
  input  logic [FREQ_W-1:0]      freq_t_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             row_index_o,
  output logic [1:0]             col_index_o,
  output logic signed [VAL_W-1:0] rate_value_o,
  output logic                   last_entry_o,
  output logic                   norm_error_o
);

  logic [MODEL_W-1:0]     model_q;
  logic [KAPPA_W-1:0]     kappa_q;
  front_t                 front;
  logic                   adv;
  div_state_e             div_st_q, div_st_d;
  logic [STEP_W-1:0]      step_q;
  div_ctrl_t              div_ctrl;
  logic                   xfer;
  logic                   buf_free;
  logic                   zero_q;
  logic [DEN_W-1:0]       den_q;
  logic [DEN3_W-1:0]      den3_q;
  lane_res_t [LANES-1:0]  lane_res;
  logic [VAL_W-1:0]       rate_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MODEL_F81;
      kappa_q <= KAPPA_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODEL: model_q <= cfg_wdata_i[MODEL_W-1:0];
        CFG_KAPPA: kappa_q <= cfg_wdata_i[KAPPA_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv        = !front.valid || div_ctrl.load;
  assign in_stall_o = !adv;

  nrmb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .model_i    (model_q),
    .kappa_i    (kappa_q),
    .freq_i     ({freq_t_i, freq_g_i, freq_c_i, freq_a_i}),
    .front_o    (front)
  );

  always_comb begin
    div_st_d = div_st_q;
    case (div_st_q)
      DIV_IDLE: begin
        if (front.valid) begin
          div_st_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (step_q == LAST_STEP) begin
          div_st_d = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (buf_free) begin
          div_st_d = front.valid ? DIV_RUN : DIV_IDLE;
        end
      end
      default: div_st_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    div_ctrl.load = 1'b0;
    div_ctrl.step = 1'b0;
    xfer          = 1'b0;
    case (div_st_q)
      DIV_IDLE: div_ctrl.load = front.valid;
      DIV_RUN:  div_ctrl.step = 1'b1;
      DIV_DONE: begin
        xfer          = buf_free;
        div_ctrl.load = buf_free && front.valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_st_q <= DIV_IDLE;
      step_q   <= '0;
    end else begin
      div_st_q <= div_st_d;
      if (div_ctrl.load) begin
        step_q <= '0;
      end else if (div_ctrl.step) begin
        step_q <= step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ctrl.load) begin
      zero_q <= front.zero;
      den_q  <= front.den;
      den3_q <= front.den3;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    nrmb_div_lane u_lane (
      .clk_i  (clk_i),
      .ctrl_i (div_ctrl),
      .num_i  (front.num[k]),
      .den_i  (div_ctrl.load ? front.den : den_q),
      .den3_i (div_ctrl.load ? front.den3 : den3_q),
      .res_o  (lane_res[k])
    );
  end

  nrmb_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .xfer_i       (xfer),
    .res_i        (lane_res),
    .err_i        (zero_q),
    .buf_free_o   (buf_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_index_o  (row_index_o),
    .col_index_o  (col_index_o),
    .rate_value_o (rate_value),
    .last_entry_o (last_entry_o),
    .norm_error_o (norm_error_o)
  );

  assign rate_value_o = rate_value;

  a_no_load_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st_q == DIV_RUN |-> !div_ctrl.load)
    else $error("divider lanes reloaded mid-divide");

  a_divide_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctrl.load |-> ##18 div_st_q == DIV_DONE)
    else $error("divide did not finish after the expected step count");

  a_hold_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_st_q == DIV_DONE && !buf_free) |=> div_st_q == DIV_DONE)
    else $error("lane results dropped while the buffer was busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && norm_error_o) |-> rate_value_o == '0)
    else $error("nonzero entry with zero normalizer");

endmodule
